// File: rtl/sobel_pkg.sv
// Shared types, constants and the Sobel coefficient function for the
// Sobel edge magnitude core. No dependencies.
`timescale 1ns / 1ps

package sobel_pkg;

  localparam int PIXEL_W       = 8;
  localparam int PIXEL_BITS    = 8;
  localparam int COEF_W        = 3;
  localparam int TERM_W        = PIXEL_BITS + COEF_W;
  localparam int SUM_W         = 16;
  localparam int SQ_W          = 2 * SUM_W;
  localparam int ROOT_W        = SUM_W;
  localparam int DIV_W         = 8;
  localparam int OUT_W         = 11;
  localparam int STEPS         = ROOT_W;
  localparam int CNT_W         = $clog2(STEPS);

  localparam logic [DIV_W-1:0]  DIVISOR_RESET = DIV_W'(8);
  localparam logic [OUT_W-1:0]  OUT_MAX       = {OUT_W{1'b1}};
  localparam logic [SQ_W-1:0]   ROOT_BIT_INIT = SQ_W'(1) << (SQ_W - 2);
  localparam logic [CNT_W-1:0]  CNT_LAST      = CNT_W'(STEPS - 1);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_SUM,
    ST_ROOT,
    ST_DIV_INIT,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic acc;
    logic mul_x;
    logic mul_y;
    logic root_init;
    logic root_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // Sobel coefficient for a mask position; row or column three gives zero.
  function automatic logic signed [COEF_W-1:0] sobel_coef(
    input logic       pattern,
    input logic [1:0] row,
    input logic [1:0] col
  );
    logic [1:0] along;
    logic [1:0] across;
    logic signed [COEF_W-1:0] weight;
    logic signed [COEF_W-1:0] coef;
    along  = pattern ? row : col;
    across = pattern ? col : row;
    case (across)
      2'd0, 2'd2: weight = COEF_W'(1);
      2'd1:       weight = COEF_W'(2);
      default:    weight = '0;
    endcase
    case (along)
      2'd0:    coef = -weight;
      2'd2:    coef = weight;
      default: coef = '0;
    endcase
    return coef;
  endfunction

endpackage

// File: rtl/sobel_edge_magnitude_core.sv
// Top level of the Sobel edge magnitude core: controller plus datapath.
// Depends on sobel_pkg, sobel_ctrl and sobel_dp.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    pattern, window_row, window_col, pixel, finish
//   out      out_valid / out_ready  edge_magnitude
//   cfg      cfg_write              cfg_data (magnitude divisor)
//
// Items without finish are accepted back to back.
// A finish item holds the input off while the controller squares both sums
// in the shared squarer, runs the bit-serial square root and the divider,
// and loads the output register, waiting while that register is still full.
// Reset clears both sums, sets the divisor to 8 and empties the output register.
`timescale 1ns / 1ps

module sobel_edge_magnitude_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         pattern,
  input  logic [1:0]                   window_row,
  input  logic [1:0]                   window_col,
  input  logic [sobel_pkg::PIXEL_W-1:0] pixel,
  input  logic                         finish,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sobel_pkg::OUT_W-1:0]  edge_magnitude,
  input  logic                         cfg_write,
  input  logic [sobel_pkg::DIV_W-1:0]  cfg_data
);
  import sobel_pkg::*;

  cmd_t    cmd;
  status_t status;

  sobel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .finish   (finish),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sobel_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .pattern        (pattern),
    .window_row     (window_row),
    .window_col     (window_col),
    .pixel          (pixel),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .edge_magnitude (edge_magnitude),
    .status         (status)
  );

  a_finish_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && finish) |=> !in_ready)
    else $error("Input still ready after a finish item.");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("Result loaded over an unaccepted result.");

  a_ready_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (in_ready && out_valid))
    else $error("Block not ready with a result after load.");

  a_single_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.acc, cmd.mul_x, cmd.mul_y, cmd.root_init, cmd.root_step,
              cmd.div_init, cmd.div_step, cmd.load_out}))
    else $error("More than one datapath command active.");

endmodule

// File: rtl/sobel_ctrl.sv
// Controller state machine for the Sobel edge magnitude core.
// Depends on sobel_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps

module sobel_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              finish,
  input  sobel_pkg::status_t status,
  output logic              in_ready,
  output sobel_pkg::cmd_t   cmd
);
  import sobel_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (finish) begin
            state_next = ST_SQ_X;
          end
        end
      end
      ST_SQ_X: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd.mul_y  = 1'b1;
        state_next = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        cmd.root_init = 1'b1;
        cnt_next      = '0;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          state_next = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/sobel_dp.sv
// Datapath of the Sobel edge magnitude core: accumulators, shared squarer,
// bit-serial square root, bit-serial divider and output register. Uses sobel_pkg.
`timescale 1ns / 1ps

module sobel_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  sobel_pkg::cmd_t              cmd,
  input  logic                         pattern,
  input  logic [1:0]                   window_row,
  input  logic [1:0]                   window_col,
  input  logic [sobel_pkg::PIXEL_W-1:0] pixel,
  input  logic                         cfg_write,
  input  logic [sobel_pkg::DIV_W-1:0]  cfg_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [sobel_pkg::OUT_W-1:0]  edge_magnitude,
  output sobel_pkg::status_t           status
);
  import sobel_pkg::*;

  logic signed [SUM_W-1:0]    x_sum;
  logic signed [SUM_W-1:0]    y_sum;
  logic [DIV_W-1:0]           divisor;
  logic signed [SQ_W-1:0]     prod;
  logic [SQ_W-1:0]            sq_x;
  logic [SQ_W-1:0]            rad;
  logic [SQ_W-1:0]            root;
  logic [SQ_W-1:0]            root_bit;
  logic [ROOT_W-1:0]          quot;
  logic [DIV_W-1:0]           rem;

  logic signed [PIXEL_BITS:0] pix_s;
  logic signed [COEF_W-1:0]   coef;
  logic signed [TERM_W-1:0]   term;
  logic signed [SUM_W-1:0]    acc_sel;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_sat;
  logic signed [SUM_W-1:0]    mul_op;
  logic [SQ_W-1:0]            trial;
  logic                       root_take;
  logic [DIV_W-1:0]           div_eff;
  logic [DIV_W:0]             shifted;
  logic                       div_take;

  always_comb begin
    pix_s    = signed'({1'b0, pixel[PIXEL_BITS-1:0]});
    coef     = sobel_coef(pattern, window_row, window_col);
    term     = TERM_W'(pix_s) * TERM_W'(coef);
    acc_sel  = pattern ? y_sum : x_sum;
    sum_wide = (SUM_W+1)'(acc_sel) + (SUM_W+1)'(term);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  assign mul_op    = cmd.mul_y ? y_sum : x_sum;
  assign trial     = root + root_bit;
  assign root_take = rad >= trial;
  assign div_eff   = (divisor == '0) ? DIV_W'(1) : divisor;
  assign shifted   = {rem, quot[ROOT_W-1]};
  assign div_take  = shifted >= {1'b0, div_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      x_sum     <= '0;
      y_sum     <= '0;
      divisor   <= DIVISOR_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        divisor <= cfg_data;
      end
      if (cmd.load_out) begin
        x_sum <= '0;
        y_sum <= '0;
      end else if (cmd.acc) begin
        if (pattern) begin
          y_sum <= sum_sat;
        end else begin
          x_sum <= sum_sat;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y) begin
      prod <= SQ_W'(mul_op) * SQ_W'(mul_op);
    end
    if (cmd.mul_y) begin
      sq_x <= unsigned'(prod);
    end
    if (cmd.root_init) begin
      rad      <= sq_x + unsigned'(prod);
      root     <= '0;
      root_bit <= ROOT_BIT_INIT;
    end else if (cmd.root_step) begin
      if (root_take) begin
        rad  <= rad - trial;
        root <= (root >> 1) + root_bit;
      end else begin
        root <= root >> 1;
      end
      root_bit <= root_bit >> 2;
    end
    if (cmd.div_init) begin
      quot <= root[ROOT_W-1:0];
      rem  <= '0;
    end else if (cmd.div_step) begin
      rem  <= div_take ? DIV_W'(shifted - {1'b0, div_eff}) : shifted[DIV_W-1:0];
      quot <= {quot[ROOT_W-2:0], div_take};
    end
    if (cmd.load_out) begin
      edge_magnitude <= (quot > ROOT_W'(OUT_MAX)) ? OUT_MAX : quot[OUT_W-1:0];
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule
